// ----- rtl/core/aesctr_pkg.sv -----
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared constants and AES round functions for the counter-mode byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aesctr_pkg;

    localparam int unsigned BlockBytes = 16;
    localparam int unsigned RoundCount = 14;

    localparam logic [2:0] CfgKey0 = 3'd0;
    localparam logic [2:0] CfgKey1 = 3'd1;
    localparam logic [2:0] CfgKey2 = 3'd2;
    localparam logic [2:0] CfgKey3 = 3'd3;

    localparam logic [127:0] StartCounter = 128'h0001020a0b0c1415_16646566_6e6f7078;

    typedef struct packed {
        logic        start;
        logic [127:0] ctr;
        logic [255:0] key;
    } t_eng_req;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] y;
        case (x)
            8'h00: y = 8'h63; 8'h01: y = 8'h7c; 8'h02: y = 8'h77; 8'h03: y = 8'h7b;
            8'h04: y = 8'hf2; 8'h05: y = 8'h6b; 8'h06: y = 8'h6f; 8'h07: y = 8'hc5;
            8'h08: y = 8'h30; 8'h09: y = 8'h01; 8'h0a: y = 8'h67; 8'h0b: y = 8'h2b;
            8'h0c: y = 8'hfe; 8'h0d: y = 8'hd7; 8'h0e: y = 8'hab; 8'h0f: y = 8'h76;
            8'h10: y = 8'hca; 8'h11: y = 8'h82; 8'h12: y = 8'hc9; 8'h13: y = 8'h7d;
            8'h14: y = 8'hfa; 8'h15: y = 8'h59; 8'h16: y = 8'h47; 8'h17: y = 8'hf0;
            8'h18: y = 8'had; 8'h19: y = 8'hd4; 8'h1a: y = 8'ha2; 8'h1b: y = 8'haf;
            8'h1c: y = 8'h9c; 8'h1d: y = 8'ha4; 8'h1e: y = 8'h72; 8'h1f: y = 8'hc0;
            8'h20: y = 8'hb7; 8'h21: y = 8'hfd; 8'h22: y = 8'h93; 8'h23: y = 8'h26;
            8'h24: y = 8'h36; 8'h25: y = 8'h3f; 8'h26: y = 8'hf7; 8'h27: y = 8'hcc;
            8'h28: y = 8'h34; 8'h29: y = 8'ha5; 8'h2a: y = 8'he5; 8'h2b: y = 8'hf1;
            8'h2c: y = 8'h71; 8'h2d: y = 8'hd8; 8'h2e: y = 8'h31; 8'h2f: y = 8'h15;
            8'h30: y = 8'h04; 8'h31: y = 8'hc7; 8'h32: y = 8'h23; 8'h33: y = 8'hc3;
            8'h34: y = 8'h18; 8'h35: y = 8'h96; 8'h36: y = 8'h05; 8'h37: y = 8'h9a;
            8'h38: y = 8'h07; 8'h39: y = 8'h12; 8'h3a: y = 8'h80; 8'h3b: y = 8'he2;
            8'h3c: y = 8'heb; 8'h3d: y = 8'h27; 8'h3e: y = 8'hb2; 8'h3f: y = 8'h75;
            8'h40: y = 8'h09; 8'h41: y = 8'h83; 8'h42: y = 8'h2c; 8'h43: y = 8'h1a;
            8'h44: y = 8'h1b; 8'h45: y = 8'h6e; 8'h46: y = 8'h5a; 8'h47: y = 8'ha0;
            8'h48: y = 8'h52; 8'h49: y = 8'h3b; 8'h4a: y = 8'hd6; 8'h4b: y = 8'hb3;
            8'h4c: y = 8'h29; 8'h4d: y = 8'he3; 8'h4e: y = 8'h2f; 8'h4f: y = 8'h84;
            8'h50: y = 8'h53; 8'h51: y = 8'hd1; 8'h52: y = 8'h00; 8'h53: y = 8'hed;
            8'h54: y = 8'h20; 8'h55: y = 8'hfc; 8'h56: y = 8'hb1; 8'h57: y = 8'h5b;
            8'h58: y = 8'h6a; 8'h59: y = 8'hcb; 8'h5a: y = 8'hbe; 8'h5b: y = 8'h39;
            8'h5c: y = 8'h4a; 8'h5d: y = 8'h4c; 8'h5e: y = 8'h58; 8'h5f: y = 8'hcf;
            8'h60: y = 8'hd0; 8'h61: y = 8'hef; 8'h62: y = 8'haa; 8'h63: y = 8'hfb;
            8'h64: y = 8'h43; 8'h65: y = 8'h4d; 8'h66: y = 8'h33; 8'h67: y = 8'h85;
            8'h68: y = 8'h45; 8'h69: y = 8'hf9; 8'h6a: y = 8'h02; 8'h6b: y = 8'h7f;
            8'h6c: y = 8'h50; 8'h6d: y = 8'h3c; 8'h6e: y = 8'h9f; 8'h6f: y = 8'ha8;
            8'h70: y = 8'h51; 8'h71: y = 8'ha3; 8'h72: y = 8'h40; 8'h73: y = 8'h8f;
            8'h74: y = 8'h92; 8'h75: y = 8'h9d; 8'h76: y = 8'h38; 8'h77: y = 8'hf5;
            8'h78: y = 8'hbc; 8'h79: y = 8'hb6; 8'h7a: y = 8'hda; 8'h7b: y = 8'h21;
            8'h7c: y = 8'h10; 8'h7d: y = 8'hff; 8'h7e: y = 8'hf3; 8'h7f: y = 8'hd2;
            8'h80: y = 8'hcd; 8'h81: y = 8'h0c; 8'h82: y = 8'h13; 8'h83: y = 8'hec;
            8'h84: y = 8'h5f; 8'h85: y = 8'h97; 8'h86: y = 8'h44; 8'h87: y = 8'h17;
            8'h88: y = 8'hc4; 8'h89: y = 8'ha7; 8'h8a: y = 8'h7e; 8'h8b: y = 8'h3d;
            8'h8c: y = 8'h64; 8'h8d: y = 8'h5d; 8'h8e: y = 8'h19; 8'h8f: y = 8'h73;
            8'h90: y = 8'h60; 8'h91: y = 8'h81; 8'h92: y = 8'h4f; 8'h93: y = 8'hdc;
            8'h94: y = 8'h22; 8'h95: y = 8'h2a; 8'h96: y = 8'h90; 8'h97: y = 8'h88;
            8'h98: y = 8'h46; 8'h99: y = 8'hee; 8'h9a: y = 8'hb8; 8'h9b: y = 8'h14;
            8'h9c: y = 8'hde; 8'h9d: y = 8'h5e; 8'h9e: y = 8'h0b; 8'h9f: y = 8'hdb;
            8'ha0: y = 8'he0; 8'ha1: y = 8'h32; 8'ha2: y = 8'h3a; 8'ha3: y = 8'h0a;
            8'ha4: y = 8'h49; 8'ha5: y = 8'h06; 8'ha6: y = 8'h24; 8'ha7: y = 8'h5c;
            8'ha8: y = 8'hc2; 8'ha9: y = 8'hd3; 8'haa: y = 8'hac; 8'hab: y = 8'h62;
            8'hac: y = 8'h91; 8'had: y = 8'h95; 8'hae: y = 8'he4; 8'haf: y = 8'h79;
            8'hb0: y = 8'he7; 8'hb1: y = 8'hc8; 8'hb2: y = 8'h37; 8'hb3: y = 8'h6d;
            8'hb4: y = 8'h8d; 8'hb5: y = 8'hd5; 8'hb6: y = 8'h4e; 8'hb7: y = 8'ha9;
            8'hb8: y = 8'h6c; 8'hb9: y = 8'h56; 8'hba: y = 8'hf4; 8'hbb: y = 8'hea;
            8'hbc: y = 8'h65; 8'hbd: y = 8'h7a; 8'hbe: y = 8'hae; 8'hbf: y = 8'h08;
            8'hc0: y = 8'hba; 8'hc1: y = 8'h78; 8'hc2: y = 8'h25; 8'hc3: y = 8'h2e;
            8'hc4: y = 8'h1c; 8'hc5: y = 8'ha6; 8'hc6: y = 8'hb4; 8'hc7: y = 8'hc6;
            8'hc8: y = 8'he8; 8'hc9: y = 8'hdd; 8'hca: y = 8'h74; 8'hcb: y = 8'h1f;
            8'hcc: y = 8'h4b; 8'hcd: y = 8'hbd; 8'hce: y = 8'h8b; 8'hcf: y = 8'h8a;
            8'hd0: y = 8'h70; 8'hd1: y = 8'h3e; 8'hd2: y = 8'hb5; 8'hd3: y = 8'h66;
            8'hd4: y = 8'h48; 8'hd5: y = 8'h03; 8'hd6: y = 8'hf6; 8'hd7: y = 8'h0e;
            8'hd8: y = 8'h61; 8'hd9: y = 8'h35; 8'hda: y = 8'h57; 8'hdb: y = 8'hb9;
            8'hdc: y = 8'h86; 8'hdd: y = 8'hc1; 8'hde: y = 8'h1d; 8'hdf: y = 8'h9e;
            8'he0: y = 8'he1; 8'he1: y = 8'hf8; 8'he2: y = 8'h98; 8'he3: y = 8'h11;
            8'he4: y = 8'h69; 8'he5: y = 8'hd9; 8'he6: y = 8'h8e; 8'he7: y = 8'h94;
            8'he8: y = 8'h9b; 8'he9: y = 8'h1e; 8'hea: y = 8'h87; 8'heb: y = 8'he9;
            8'hec: y = 8'hce; 8'hed: y = 8'h55; 8'hee: y = 8'h28; 8'hef: y = 8'hdf;
            8'hf0: y = 8'h8c; 8'hf1: y = 8'ha1; 8'hf2: y = 8'h89; 8'hf3: y = 8'h0d;
            8'hf4: y = 8'hbf; 8'hf5: y = 8'he6; 8'hf6: y = 8'h42; 8'hf7: y = 8'h68;
            8'hf8: y = 8'h41; 8'hf9: y = 8'h99; 8'hfa: y = 8'h2d; 8'hfb: y = 8'h0f;
            8'hfc: y = 8'hb0; 8'hfd: y = 8'h54; 8'hfe: y = 8'hbb; default: y = 8'h16;
        endcase
        return y;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // State byte i sits at bits 127-8i; byte 4c+r is row r of column c.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/aes256_ctr_byte_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// aes256_ctr_byte_stream_cipher
// AES-256 counter-mode byte cipher: each byte is XORed with the keystream.
// ----------------------------------------------------------------------------
// Bytes pass at one per cycle while keystream is on hand and the output is not
// stalled. The first byte and every sixteenth byte after it wait for a new
// keystream block, which the round engine computes one AES round per cycle.
// Writing any key register restarts the counter at its fixed starting value
// and drops the keystream; do so only while no bytes are in flight.
`default_nettype none

module aes256_ctr_byte_stream_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_data_out,
    output logic             o_last_out
);

    logic [255:0] r_key;
    logic [127:0] r_ctr;
    logic [127:0] r_ks;
    logic [4:0]   r_pos;
    logic         r_o_valid, r_o_last;
    logic [7:0]   r_o_data;

    logic         q_valid, q_last, q_pop;
    logic [7:0]   q_data;
    logic         eng_busy, eng_done;
    logic [127:0] eng_block;
    aesctr_pkg::t_eng_req req;
    logic         key_wr;

    aesctr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data_in),
        .i_last    (i_last_in),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .o_q_last  (q_last),
        .i_q_pop   (q_pop)
    );

    aesctr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_busy  (eng_busy),
        .o_done  (eng_done),
        .o_block (eng_block)
    );

    assign key_wr = i_cfg_we && (i_cfg_index == aesctr_pkg::CfgKey0 ||
                                 i_cfg_index == aesctr_pkg::CfgKey1 ||
                                 i_cfg_index == aesctr_pkg::CfgKey2 ||
                                 i_cfg_index == aesctr_pkg::CfgKey3);

    assign q_pop = q_valid && (r_pos < 5'(aesctr_pkg::BlockBytes)) &&
                   (!r_o_valid || !i_stall);

    assign req.start = q_valid && (r_pos == 5'(aesctr_pkg::BlockBytes)) &&
                       !eng_busy && !eng_done && !key_wr;
    assign req.ctr   = r_ctr;
    assign req.key   = r_key;

    assign o_valid    = r_o_valid;
    assign o_data_out = r_o_data;
    assign o_last_out = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_ctr     <= aesctr_pkg::StartCounter;
            r_pos     <= 5'(aesctr_pkg::BlockBytes);
            r_o_valid <= 1'b0;
        end else begin
            if (key_wr) begin
                case (i_cfg_index)
                    aesctr_pkg::CfgKey0: r_key[255:192] <= i_cfg_data;
                    aesctr_pkg::CfgKey1: r_key[191:128] <= i_cfg_data;
                    aesctr_pkg::CfgKey2: r_key[127:64]  <= i_cfg_data;
                    default:             r_key[63:0]    <= i_cfg_data;
                endcase
                r_ctr <= aesctr_pkg::StartCounter;
                r_pos <= 5'(aesctr_pkg::BlockBytes);
            end else if (eng_done) begin
                r_ctr <= r_ctr + 128'd1;
                r_pos <= 5'd0;
            end else if (q_pop) begin
                r_pos <= r_pos + 5'd1;
            end
            if (q_pop) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (eng_done) begin
            r_ks <= eng_block;
        end
        if (q_pop) begin
            r_o_data <= q_data ^ r_ks[127 - 8 * r_pos[3:0] -: 8];
            r_o_last <= q_last;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 5'(aesctr_pkg::BlockBytes)) else $error("byte position out of range");
    a_no_refill_with_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> !q_pop) else $error("refill started while keystream remains");
    a_done_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_done && !key_wr) |=> r_pos == 5'd0)
        else $error("keystream refill did not rewind the byte position");

endmodule

`default_nettype wire

// ----- rtl/core/aesctr_front.sv -----
// ----------------------------------------------------------------------------
// aesctr_front
// Two-entry input queue that takes bytes and flags from the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aesctr_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    output logic            o_q_valid,
    output logic [7:0]      o_q_data,
    output logic            o_q_last,
    input  wire logic       i_q_pop
);

    logic [8:0] r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push;

    assign o_stall   = (r_count == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_data  = r_mem[r_rd_ptr][8:1];
    assign o_q_last  = r_mem[r_rd_ptr][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_q_pop};
        end
        if (push) begin
            r_mem[r_wr_ptr] <= {i_data, i_last};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("input queue count out of range");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty input queue");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// ----- rtl/core/aesctr_engine.sv -----
// ----------------------------------------------------------------------------
// aesctr_engine
// Iterative AES-256 block encryptor, one round per cycle, with round keys
// generated on the fly from a sliding eight-word key window.
// ----------------------------------------------------------------------------
`default_nettype none

module aesctr_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire aesctr_pkg::t_eng_req i_req,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [127:0]              o_block
);

    logic         r_busy, r_done, r_rot;
    logic [3:0]   r_round;
    logic [7:0]   r_rcon;
    logic [127:0] r_state;
    logic [255:0] r_win;
    logic [127:0] n_state;
    logic [127:0] n_keys;
    logic [31:0]  t;

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_block = r_state;

    always_comb begin
        n_state = aesctr_pkg::sub_shift(r_state);
        if (r_round != 4'(aesctr_pkg::RoundCount)) begin
            n_state = aesctr_pkg::mix_columns(n_state);
        end
        n_state = n_state ^ r_win[127:0];

        // Next four schedule words; the rotate and round constant apply on
        // every other group of four.
        if (r_rot) begin
            t = aesctr_pkg::sub_word({r_win[23:0], r_win[31:24]}) ^ {r_rcon, 24'h0};
        end else begin
            t = aesctr_pkg::sub_word(r_win[31:0]);
        end
        n_keys[127:96] = r_win[255:224] ^ t;
        n_keys[95:64]  = r_win[223:192] ^ n_keys[127:96];
        n_keys[63:32]  = r_win[191:160] ^ n_keys[95:64];
        n_keys[31:0]   = r_win[159:128] ^ n_keys[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_round == 4'(aesctr_pkg::RoundCount)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start && !r_busy) begin
            r_state <= i_req.ctr ^ i_req.key[255:128];
            r_win   <= i_req.key;
            r_round <= 4'd1;
            r_rcon  <= 8'h01;
            r_rot   <= 1'b1;
        end else if (r_busy) begin
            r_state <= n_state;
            r_win   <= {r_win[127:0], n_keys};
            r_round <= r_round + 4'd1;
            r_rot   <= !r_rot;
            if (r_rot) begin
                r_rcon <= aesctr_pkg::xtime(r_rcon);
            end
        end
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_round >= 4'd1 && r_round <= 4'(aesctr_pkg::RoundCount)))
        else $error("round counter out of range while busy");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("done without finishing the last round");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy) |=> r_busy) else $error("start was lost");

endmodule

`default_nettype wire

// ----- bench/aes256_ctr_byte_stream_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// aes256_ctr_byte_stream_cipher_tb
// Streams bytes through the AES-256 counter-mode cipher under several keys.
// Every output word is checked against a local AES-256 keystream model, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module aes256_ctr_byte_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CfgNoRegFirst = 3'd4;
    localparam logic [2:0] CfgNoRegLast  = 3'd7;
    localparam int unsigned DrainCycles  = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_in = '0;
    logic        i_last_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_data_out;
    logic        o_last_out;

    aes256_ctr_byte_stream_cipher dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Forward S-box, kept here so the keystream model is independent of the RTL.
    logic [7:0] sub_byte_tbl [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [63:0]  key_regs [4];
    logic [31:0]  sched [60];
    logic [127:0] ctr_value;
    logic [7:0]   pad [16];
    int unsigned  pad_pos;

    t_byte_word   send_q [$];
    t_byte_word   cipher_q [$];
    int unsigned  errors = 0;
    int unsigned  bytes_in = 0;
    int unsigned  bytes_out = 0;
    int unsigned  blocks_made = 0;
    int unsigned  key_loads = 0;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sub_byte_tbl[w[31:24]], sub_byte_tbl[w[23:16]],
                sub_byte_tbl[w[15:8]], sub_byte_tbl[w[7:0]]};
    endfunction

    // Writing a key register rebuilds the schedule and restarts the counter;
    // indexes past the last key register change nothing.
    task automatic load_key_reg(input logic [2:0] idx, input logic [63:0] val);
        logic [31:0] t;
        logic [7:0]  rc;
        if (idx > aesctr_pkg::CfgKey3) return;
        key_regs[idx] = val;
        for (int i = 0; i < 4; i++) begin
            sched[2 * i]     = key_regs[i][63:32];
            sched[2 * i + 1] = key_regs[i][31:0];
        end
        rc = 8'h01;
        for (int i = 8; i < 60; i++) begin
            t = sched[i - 1];
            if (i % 8 == 0) begin
                t  = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (i % 8 == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i - 8] ^ t;
        end
        ctr_value = aesctr_pkg::StartCounter;
        pad_pos   = 16;
    endtask

    task automatic add_round_key(inout logic [7:0] s [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
    endtask

    task automatic sub_and_shift(inout logic [7:0] s [16]);
        logic [7:0] t [16];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4 * c + r] = sub_byte_tbl[s[4 * ((c + r) % 4) + r]];
        s = t;
    endtask

    task automatic next_pad_block();
        logic [7:0] s [16];
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) s[i] = ctr_value[127 - 8 * i -: 8];
        add_round_key(s, 0);
        for (int rnd = 1; rnd <= 14; rnd++) begin
            sub_and_shift(s);
            if (rnd < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            add_round_key(s, rnd);
        end
        pad = s;
        ctr_value = ctr_value + 128'd1;
        blocks_made++;
    endtask

    task automatic cipher_byte(input logic [7:0] d, input logic last);
        t_byte_word w;
        if (pad_pos >= 16) begin
            next_pad_block();
            pad_pos = 0;
        end
        w.data = d ^ pad[pad_pos];
        w.last = last;
        cipher_q.push_back(w);
        pad_pos++;
    endtask

    // Input side: present queued words, with a random gap after each accepted one.
    int unsigned in_gap = 0;
    bit          in_burst = 1'b0;
    always @(posedge i_clk) begin
        t_byte_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cipher_byte(i_data_in, i_last_in);
                bytes_in++;
                if ($urandom_range(0, 47) == 0) in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 3);
            end
            if (!(i_valid && o_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    w = send_q.pop_front();
                    i_valid   <= 1'b1;
                    i_data_in <= w.data;
                    i_last_in <= w.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted word, then stall for a random count.
    int unsigned out_hold = 0;
    bit          out_burst = 1'b0;
    always @(posedge i_clk) begin
        t_byte_word exp_w;
        if (o_valid && !i_stall) begin
            bytes_out++;
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected word data=%02h last=%0b",
                         $realtime, o_data_out, o_last_out);
                errors++;
            end else begin
                exp_w = cipher_q.pop_front();
                if (o_data_out !== exp_w.data) begin
                    $display("%0t: data mismatch, expected %02h, actual %02h",
                             $realtime, exp_w.data, o_data_out);
                    errors++;
                end
                if (o_last_out !== exp_w.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $realtime, exp_w.last, o_last_out);
                    errors++;
                end
            end
            if ($urandom_range(0, 47) == 0) out_burst = !out_burst;
            out_hold = out_burst ? 0 : $urandom_range(0, 3);
        end else if (out_hold > 0) begin
            out_hold--;
        end
        i_stall <= (out_hold != 0);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        load_key_reg(idx, val);
        key_loads++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (send_q.size() > 0 || cipher_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic queue_random(input int unsigned n);
        t_byte_word w;
        for (int unsigned k = 0; k < n; k++) begin
            w.data = $urandom_range(0, 255);
            w.last = ($urandom_range(0, 7) == 0);
            send_q.push_back(w);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_byte_word w;
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        load_key_reg(aesctr_pkg::CfgKey0, 64'h0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key: byte extremes and alternating patterns across two blocks.
        for (int k = 0; k < 20; k++) begin
            case (k % 4)
                0: w.data = 8'h00;
                1: w.data = 8'hff;
                2: w.data = 8'h55;
                default: w.data = 8'haa;
            endcase
            w.last = k[0];
            send_q.push_back(w);
        end
        wait_idle();

        // All-ones key, plus writes to unused indexes that must be ignored.
        write_reg(aesctr_pkg::CfgKey0, '1);
        write_reg(aesctr_pkg::CfgKey1, '1);
        write_reg(aesctr_pkg::CfgKey2, '1);
        write_reg(aesctr_pkg::CfgKey3, '1);
        write_reg(CfgNoRegFirst, rand64());
        write_reg(CfgNoRegLast, '0);
        queue_random(100);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                // Rewriting one register alone still restarts the counter.
                write_reg(aesctr_pkg::CfgKey2, key_regs[aesctr_pkg::CfgKey2]);
            end else begin
                write_reg(aesctr_pkg::CfgKey0, rand64());
                write_reg(aesctr_pkg::CfgKey1, rand64());
                write_reg(aesctr_pkg::CfgKey2, rand64());
                write_reg(aesctr_pkg::CfgKey3, rand64());
                write_reg(3'($urandom_range(CfgNoRegFirst, CfgNoRegLast)), rand64());
            end
            queue_random($urandom_range(80, 140));
            wait_idle();
        end

        write_reg(aesctr_pkg::CfgKey0, '0);
        write_reg(aesctr_pkg::CfgKey1, '0);
        write_reg(aesctr_pkg::CfgKey2, '0);
        write_reg(aesctr_pkg::CfgKey3, '0);
        queue_random(40);
        wait_idle();

        $display("Sent %0d bytes and checked %0d, using %0d keystream blocks",
                 bytes_in, bytes_out, blocks_made);
        $display("over %0d register writes with zero, all-ones and random keys.",
                 key_loads);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d words still expected", cipher_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
